@@ rtl/core/dsfmt_pkg.sv @@
// Shared constants, types and codes for the dSFMT prototype generator.
`timescale 1ns / 1ps

package dsfmt_pkg;

  localparam int ENTRIES_DEFAULT = 191;
  localparam int WORD_W          = 64;
  localparam int HALF_W          = 32;
  localparam int MASK_W          = 52;
  localparam int PICK_W          = 8;
  localparam int SHIFT_W         = 6;
  localparam int RSHIFT          = 12;
  localparam int LCG_SHIFT       = 62;
  localparam logic [WORD_W-1:0] LCG_MULT = 64'h5851_F42D_4C95_7F2D;

  // Seed chain index, wide enough for the largest table.
  localparam int SEED_IDX_W = 12;

  // Configuration port geometry: 64-bit registers at 8-byte strides.
  localparam int APB_AW      = 5;
  localparam int APB_DW      = 64;
  localparam int CFG_IDX_LSB = 3;

  localparam logic [PICK_W-1:0]  PICK_RESET  = 8'd1;
  localparam logic [SHIFT_W-1:0] SHIFT_RESET = 6'd13;

  typedef enum logic [1:0] {
    CFG_PICK_OFFSET = 2'd0,
    CFG_LEFT_SHIFT  = 2'd1,
    CFG_MASK_FIRST  = 2'd2,
    CFG_MASK_SECOND = 2'd3
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEED_STORE,
    ST_SEED_MUL,
    ST_CALC,
    ST_NEXT,
    ST_SEND
  } gen_state_t;

  typedef enum logic [1:0] {
    PH_LO,
    PH_CROSS_A,
    PH_CROSS_B
  } lcg_phase_t;

  typedef struct packed {
    logic                  start;
    logic [WORD_W-1:0]     x;
    logic [SEED_IDX_W-1:0] index;
  } lcg_req_t;

  typedef struct packed {
    logic              done;
    logic [WORD_W-1:0] value;
  } lcg_rsp_t;

endpackage

@@ rtl/core/dsfmt_in_if.sv @@
// Command channel: mode, seed and straddle select with valid/ready.
`timescale 1ns / 1ps

interface dsfmt_in_if;
  logic        valid;
  logic        ready;
  logic        mode;
  logic [63:0] seed_value;
  logic        straddle;

  modport source (output valid, mode, seed_value, straddle, input ready);
  modport sink (input valid, mode, seed_value, straddle, output ready);
endinterface

@@ rtl/core/dsfmt_out_if.sv @@
// Result channel: one output pair with valid/ready.
`timescale 1ns / 1ps

interface dsfmt_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] out_first;
  logic [63:0] out_second;

  modport source (output valid, out_first, out_second, input ready);
  modport sink (input valid, out_first, out_second, output ready);
endinterface

@@ rtl/core/dsfmt_prototype_generator.sv @@
// Top level of the dSFMT prototype generator: state memories, recursion and control.
`timescale 1ns / 1ps

// The state table sits in two synchronous memories (first and second words), each
// with one write port and two registered read ports. A generate transaction reads the
// current entry on port A and its partner entry on port B at the accept edge, then in
// the following cycle runs the recursion, writes the entry back and moves the read
// position on. A straddled generate goes on into a further state, since the first
// word of the next entry is fetched on port A after the partner read. A result is
// held in an output register, so the next command is taken while it waits; a full
// output register holds the block back only when the consumer stalls. A seed
// transaction gives no result; it runs the 2*ENTRIES+1 chain steps on the single
// 32x32 multiplier and stores each of the 2*ENTRIES+2 words. There is no clearing
// pass after reset; generating before the first seed returns whatever the memories
// hold. Configuration lives at byte addresses 0, 8, 16 and 24 (pick offset, left
// shift, first mask, second mask).
module dsfmt_prototype_generator #(
  parameter int ENTRIES = dsfmt_pkg::ENTRIES_DEFAULT
) (
  input  logic                         clk,
  input  logic                         rst,
  dsfmt_in_if.sink                     cmd,
  dsfmt_out_if.source                  rsp,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [dsfmt_pkg::APB_AW-1:0] paddr,
  input  logic [dsfmt_pkg::APB_DW-1:0] pwdata,
  output logic [dsfmt_pkg::APB_DW-1:0] prdata,
  output logic                         pready
);

  localparam int AW = $clog2(ENTRIES);
  localparam int KW = $clog2(2 * ENTRIES + 2);

  // ---------------------------------------------------------------- configuration
  logic [dsfmt_pkg::PICK_W-1:0]  pick_offset;
  logic [AW-1:0]                 pick_red;     // pick_offset reduced modulo ENTRIES
  logic [dsfmt_pkg::SHIFT_W-1:0] left_shift;
  logic [dsfmt_pkg::MASK_W-1:0]  mask_first;
  logic [dsfmt_pkg::MASK_W-1:0]  mask_second;

  logic                cfg_wr;
  dsfmt_pkg::cfg_reg_t cfg_idx;
  logic [AW-1:0]       pick_tab [2**dsfmt_pkg::PICK_W];

  // Constant reduction table, worked out at elaboration.
  for (genvar g = 0; g < 2**dsfmt_pkg::PICK_W; g++) begin : g_pick_tab
    assign pick_tab[g] = AW'(g % ENTRIES);
  end

  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite & pready;
  assign cfg_idx = dsfmt_pkg::cfg_reg_t'(paddr[dsfmt_pkg::APB_AW-1:dsfmt_pkg::CFG_IDX_LSB]);

  always_ff @(posedge clk) begin
    if (rst) begin
      pick_offset <= dsfmt_pkg::PICK_RESET;
      pick_red    <= AW'(dsfmt_pkg::PICK_RESET);
      left_shift  <= dsfmt_pkg::SHIFT_RESET;
      mask_first  <= '0;
      mask_second <= '0;
    end else if (cfg_wr) begin
      case (cfg_idx)
        dsfmt_pkg::CFG_PICK_OFFSET: begin
          pick_offset <= pwdata[dsfmt_pkg::PICK_W-1:0];
          pick_red    <= pick_tab[pwdata[dsfmt_pkg::PICK_W-1:0]];
        end
        dsfmt_pkg::CFG_LEFT_SHIFT:  left_shift  <= pwdata[dsfmt_pkg::SHIFT_W-1:0];
        dsfmt_pkg::CFG_MASK_FIRST:  mask_first  <= pwdata[dsfmt_pkg::MASK_W-1:0];
        dsfmt_pkg::CFG_MASK_SECOND: mask_second <= pwdata[dsfmt_pkg::MASK_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      dsfmt_pkg::CFG_PICK_OFFSET: prdata = dsfmt_pkg::APB_DW'(pick_offset);
      dsfmt_pkg::CFG_LEFT_SHIFT:  prdata = dsfmt_pkg::APB_DW'(left_shift);
      dsfmt_pkg::CFG_MASK_FIRST:  prdata = dsfmt_pkg::APB_DW'(mask_first);
      dsfmt_pkg::CFG_MASK_SECOND: prdata = dsfmt_pkg::APB_DW'(mask_second);
      default:                    prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------- state
  dsfmt_pkg::gen_state_t state;
  dsfmt_pkg::gen_state_t state_next;

  logic [AW-1:0]                 pos;
  logic [dsfmt_pkg::WORD_W-1:0]  lung_first;
  logic [dsfmt_pkg::WORD_W-1:0]  lung_second;
  logic                          straddle;
  logic [dsfmt_pkg::WORD_W-1:0]  hold_first;
  logic [dsfmt_pkg::WORD_W-1:0]  hold_second;
  logic [dsfmt_pkg::WORD_W-1:0]  seed_x;
  logic [KW-1:0]                 seed_k;
  logic                          out_valid;
  logic [dsfmt_pkg::WORD_W-1:0]  out_first;
  logic [dsfmt_pkg::WORD_W-1:0]  out_second;

  // ---------------------------------------------------------------- memories
  logic [dsfmt_pkg::WORD_W-1:0] first_mem  [ENTRIES];
  logic [dsfmt_pkg::WORD_W-1:0] second_mem [ENTRIES];

  logic [AW-1:0]                addr_a;
  logic [AW-1:0]                addr_b;
  logic [AW-1:0]                wr_addr;
  logic                         wr_first_en;
  logic                         wr_second_en;
  logic [dsfmt_pkg::WORD_W-1:0] wr_first_data;
  logic [dsfmt_pkg::WORD_W-1:0] wr_second_data;
  logic [dsfmt_pkg::WORD_W-1:0] rd_a_first;
  logic [dsfmt_pkg::WORD_W-1:0] rd_a_second;
  logic [dsfmt_pkg::WORD_W-1:0] rd_b_first;
  logic [dsfmt_pkg::WORD_W-1:0] rd_b_second;

  // The reads that an item uses never hit the entry written in that cycle: its reads
  // are issued at the accept edge (no write then), and the straddle read targets the next
  // entry while the current one is written.
  always_ff @(posedge clk) begin
    if (wr_first_en) begin
      first_mem[wr_addr] <= wr_first_data;
    end
    rd_a_first <= first_mem[addr_a];
    rd_b_first <= first_mem[addr_b];
  end

  always_ff @(posedge clk) begin
    if (wr_second_en) begin
      second_mem[wr_addr] <= wr_second_data;
    end
    rd_a_second <= second_mem[addr_a];
    rd_b_second <= second_mem[addr_b];
  end

  // ---------------------------------------------------------------- addressing
  logic [AW-1:0] nxt_pos;
  logic [AW:0]   partner_sum;
  logic [AW-1:0] partner;

  assign nxt_pos     = (pos == AW'(ENTRIES - 1)) ? '0 : pos + 1'b1;
  assign partner_sum = {1'b0, pos} + {1'b0, pick_red};
  assign partner     = (partner_sum >= (AW + 1)'(ENTRIES))
                     ? AW'(partner_sum - (AW + 1)'(ENTRIES))
                     : partner_sum[AW-1:0];

  // ---------------------------------------------------------------- seeding chain
  dsfmt_pkg::lcg_req_t lcg_req;
  dsfmt_pkg::lcg_rsp_t lcg_rsp;
  logic                lcg_start;

  logic [KW-2:0] seed_entry;
  logic          seed_in_table;
  logic          seed_last;

  // Word k goes to entry k/2 (odd k: second word); the last two words fill the lung.
  assign seed_entry    = seed_k[KW-1:1];
  assign seed_in_table = (seed_entry < (KW - 1)'(ENTRIES));
  assign seed_last     = (seed_k == KW'(2 * ENTRIES + 1));

  assign lcg_req.start = lcg_start;
  assign lcg_req.x     = seed_x;
  assign lcg_req.index = dsfmt_pkg::SEED_IDX_W'(seed_k + 1'b1);

  dsfmt_lcg u_lcg (
    .clk (clk),
    .rst (rst),
    .req (lcg_req),
    .rsp (lcg_rsp)
  );

  // ---------------------------------------------------------------- recursion
  logic [dsfmt_pkg::WORD_W-1:0] new_lung_first;
  logic [dsfmt_pkg::WORD_W-1:0] new_lung_second;
  logic [dsfmt_pkg::WORD_W-1:0] upd_first;
  logic [dsfmt_pkg::WORD_W-1:0] upd_second;

  // Port A holds the current entry, port B its partner; each lung word takes the
  // other one with its halves swapped.
  assign new_lung_first  = (rd_a_first << left_shift)
                         ^ {lung_second[dsfmt_pkg::HALF_W-1:0],
                            lung_second[dsfmt_pkg::WORD_W-1:dsfmt_pkg::HALF_W]}
                         ^ rd_b_first;
  assign new_lung_second = (rd_a_second << left_shift)
                         ^ {lung_first[dsfmt_pkg::HALF_W-1:0],
                            lung_first[dsfmt_pkg::WORD_W-1:dsfmt_pkg::HALF_W]}
                         ^ rd_b_second;
  assign upd_first  = (new_lung_first >> dsfmt_pkg::RSHIFT)
                    ^ (new_lung_first & dsfmt_pkg::WORD_W'(mask_first)) ^ rd_a_first;
  assign upd_second = (new_lung_second >> dsfmt_pkg::RSHIFT)
                    ^ (new_lung_second & dsfmt_pkg::WORD_W'(mask_second)) ^ rd_a_second;

  // ---------------------------------------------------------------- control
  logic                         cmd_accept;
  logic                         out_free;
  logic                         load_out;
  logic [dsfmt_pkg::WORD_W-1:0] load_first;
  logic [dsfmt_pkg::WORD_W-1:0] load_second;

  assign cmd_accept = cmd.valid & cmd.ready;
  assign out_free   = ~out_valid | rsp.ready;

  always_comb begin
    state_next = state;
    case (state)
      dsfmt_pkg::ST_IDLE: begin
        if (cmd.valid) begin
          state_next = cmd.mode ? dsfmt_pkg::ST_CALC : dsfmt_pkg::ST_SEED_STORE;
        end
      end
      dsfmt_pkg::ST_SEED_STORE: begin
        state_next = seed_last ? dsfmt_pkg::ST_IDLE : dsfmt_pkg::ST_SEED_MUL;
      end
      dsfmt_pkg::ST_SEED_MUL: begin
        if (lcg_rsp.done) state_next = dsfmt_pkg::ST_SEED_STORE;
      end
      dsfmt_pkg::ST_CALC: begin
        if (straddle)      state_next = dsfmt_pkg::ST_NEXT;
        else if (out_free) state_next = dsfmt_pkg::ST_IDLE;
        else               state_next = dsfmt_pkg::ST_SEND;
      end
      dsfmt_pkg::ST_NEXT,
      dsfmt_pkg::ST_SEND: begin
        state_next = out_free ? dsfmt_pkg::ST_IDLE : dsfmt_pkg::ST_SEND;
      end
      default: state_next = dsfmt_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd.ready      = 1'b0;
    addr_a         = pos;
    addr_b         = partner;
    wr_addr        = pos;
    wr_first_en    = 1'b0;
    wr_second_en   = 1'b0;
    wr_first_data  = upd_first;
    wr_second_data = upd_second;
    lcg_start      = 1'b0;
    load_out       = 1'b0;
    load_first     = hold_first;
    load_second    = hold_second;
    case (state)
      dsfmt_pkg::ST_IDLE: begin
        cmd.ready = 1'b1;
      end
      dsfmt_pkg::ST_SEED_STORE: begin
        wr_addr        = seed_entry[AW-1:0];
        wr_first_en    = seed_in_table & ~seed_k[0];
        wr_second_en   = seed_in_table & seed_k[0];
        wr_first_data  = seed_x;
        wr_second_data = seed_x;
        lcg_start      = ~seed_last;
      end
      dsfmt_pkg::ST_CALC: begin
        wr_first_en  = 1'b1;
        wr_second_en = 1'b1;
        addr_a       = nxt_pos;   // first word of the next entry, for a straddle
        if (!straddle && out_free) begin
          load_out    = 1'b1;
          load_first  = rd_a_first;
          load_second = rd_a_second;
        end
      end
      dsfmt_pkg::ST_NEXT: begin
        if (out_free) begin
          load_out    = 1'b1;
          load_second = rd_a_first;
        end
      end
      dsfmt_pkg::ST_SEND: begin
        load_out = out_free;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= dsfmt_pkg::ST_IDLE;
      pos         <= '0;
      lung_first  <= '0;
      lung_second <= '0;
      out_valid   <= 1'b0;
    end else begin
      state <= state_next;
      if (load_out)       out_valid <= 1'b1;
      else if (rsp.ready) out_valid <= 1'b0;
      case (state)
        dsfmt_pkg::ST_SEED_STORE: begin
          if (!seed_in_table) begin
            if (seed_k[0]) lung_second <= seed_x;
            else           lung_first  <= seed_x;
          end
          if (seed_last) pos <= '0;
        end
        dsfmt_pkg::ST_CALC: begin
          lung_first  <= new_lung_first;
          lung_second <= new_lung_second;
          pos         <= nxt_pos;
        end
        default: ;
      endcase
    end
  end

  // Payload registers: loaded before use, no reset.
  always_ff @(posedge clk) begin
    if (cmd_accept) begin
      straddle <= cmd.straddle;
      seed_x   <= cmd.seed_value;
      seed_k   <= '0;
    end
    if (state == dsfmt_pkg::ST_SEED_STORE && !seed_last) begin
      seed_k <= seed_k + 1'b1;
    end
    if (state == dsfmt_pkg::ST_SEED_MUL && lcg_rsp.done) begin
      seed_x <= lcg_rsp.value;
    end
    if (state == dsfmt_pkg::ST_CALC) begin
      hold_first  <= straddle ? rd_a_second : rd_a_first;
      hold_second <= rd_a_second;
    end
    if (state == dsfmt_pkg::ST_NEXT) begin
      hold_second <= rd_a_first;
    end
    if (load_out) begin
      out_first  <= load_first;
      out_second <= load_second;
    end
  end

  assign rsp.valid      = out_valid;
  assign rsp.out_first  = out_first;
  assign rsp.out_second = out_second;

endmodule

@@ rtl/core/dsfmt_lcg.sv @@
// One step of the 64-bit seeding chain on a 32x32 multiplier.
`timescale 1ns / 1ps

module dsfmt_lcg (
  input  logic               clk,
  input  logic               rst,
  input  dsfmt_pkg::lcg_req_t req,
  output dsfmt_pkg::lcg_rsp_t rsp
);

  dsfmt_pkg::lcg_phase_t ph;
  logic [dsfmt_pkg::WORD_W-1:0]     y_q;
  logic [dsfmt_pkg::SEED_IDX_W-1:0] idx_q;
  logic [dsfmt_pkg::WORD_W-1:0]     acc;
  logic [dsfmt_pkg::WORD_W-1:0]     acc_next;
  logic                             done;

  logic [dsfmt_pkg::WORD_W-1:0] y_in;
  logic [dsfmt_pkg::WORD_W-1:0] y_cur;
  logic [dsfmt_pkg::HALF_W-1:0] op_a;
  logic [dsfmt_pkg::HALF_W-1:0] op_b;
  logic [dsfmt_pkg::WORD_W-1:0] prod;

  assign y_in  = req.x ^ (req.x >> dsfmt_pkg::LCG_SHIFT);
  assign y_cur = (ph == dsfmt_pkg::PH_LO) ? y_in : y_q;

  // low x low, low x high, high x low: only the low 64 bits matter
  assign op_a = (ph == dsfmt_pkg::PH_CROSS_B) ? y_cur[dsfmt_pkg::WORD_W-1:dsfmt_pkg::HALF_W]
                                              : y_cur[dsfmt_pkg::HALF_W-1:0];
  assign op_b = (ph == dsfmt_pkg::PH_CROSS_A)
              ? dsfmt_pkg::LCG_MULT[dsfmt_pkg::WORD_W-1:dsfmt_pkg::HALF_W]
              : dsfmt_pkg::LCG_MULT[dsfmt_pkg::HALF_W-1:0];
  assign prod = op_a * op_b;

  always_comb begin
    case (ph)
      dsfmt_pkg::PH_LO:      acc_next = prod;
      dsfmt_pkg::PH_CROSS_A: acc_next = acc + {prod[dsfmt_pkg::HALF_W-1:0],
                                               {dsfmt_pkg::HALF_W{1'b0}}};
      dsfmt_pkg::PH_CROSS_B: acc_next = acc + {prod[dsfmt_pkg::HALF_W-1:0],
                                               {dsfmt_pkg::HALF_W{1'b0}}}
                                            + dsfmt_pkg::WORD_W'(idx_q);
      default:               acc_next = acc;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ph   <= dsfmt_pkg::PH_LO;
      done <= 1'b0;
    end else begin
      done <= (ph == dsfmt_pkg::PH_CROSS_B);
      case (ph)
        dsfmt_pkg::PH_LO:      if (req.start) ph <= dsfmt_pkg::PH_CROSS_A;
        dsfmt_pkg::PH_CROSS_A: ph <= dsfmt_pkg::PH_CROSS_B;
        dsfmt_pkg::PH_CROSS_B: ph <= dsfmt_pkg::PH_LO;
        default:               ph <= dsfmt_pkg::PH_LO;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (ph == dsfmt_pkg::PH_LO && req.start) begin
      y_q   <= y_in;
      idx_q <= req.index;
    end
    if (ph != dsfmt_pkg::PH_LO || req.start) begin
      acc <= acc_next;
    end
  end

  assign rsp.done  = done;
  assign rsp.value = acc;

endmodule

@@ rtl/core/dsfmt_checker.sv @@
// Port-level checks for the dSFMT prototype generator, bound to the top level.
`timescale 1ns / 1ps

module dsfmt_checker (
  input logic        clk,
  input logic        rst,
  input logic        cmd_valid,
  input logic        cmd_ready,
  input logic        cmd_mode,
  input logic        rsp_valid,
  input logic        rsp_ready,
  input logic [63:0] rsp_first,
  input logic [63:0] rsp_second
);

  // No result is waiting right after reset.
  a_reset_empty: assert property (@(posedge clk) rst |=> !rsp_valid)
    else $error("result valid after reset");

  // A seed transaction never produces a result.
  a_seed_silent: assert property (@(posedge clk) disable iff (rst)
    (cmd_valid && cmd_ready && !cmd_mode && !rsp_valid) |=> !rsp_valid)
    else $error("result appeared after a seed transaction");

  // The block never accepts commands on consecutive cycles.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (cmd_valid && cmd_ready) |=> !cmd_ready)
    else $error("command accepted on consecutive cycles");

  // A stalled result holds its value.
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_first) && $stable(rsp_second)))
    else $error("stalled result changed or dropped");

endmodule

bind dsfmt_prototype_generator dsfmt_checker u_dsfmt_checker (
  .clk        (clk),
  .rst        (rst),
  .cmd_valid  (cmd.valid),
  .cmd_ready  (cmd.ready),
  .cmd_mode   (cmd.mode),
  .rsp_valid  (rsp.valid),
  .rsp_ready  (rsp.ready),
  .rsp_first  (rsp.out_first),
  .rsp_second (rsp.out_second)
);
